// ===== sv/qec_pkg.sv =====
package qec_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;

  localparam int TAB_LEN = 24;
  localparam int NST     = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int AMW     = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

  localparam int ISQ_N = 29;
  localparam int XW    = 37;
  localparam int ZW    = 34;
  localparam int VW    = 58;
  localparam int MW    = 34;
  localparam int DW    = 112;

  localparam logic OPC_E2Q = 1'b0;
  localparam logic OPC_Q2E = 1'b1;

  localparam logic [31:0] KINV_Q30     = 32'd652032874;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] THREE_QUART  = 32'hC000_0000;
  localparam int          ONE_Q28      = 1 << 28;

  localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic                 rot;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  typedef struct packed {
    logic       opc;
    logic [1:0] q0;
    logic [1:0] q1;
    logic [1:0] q2;
    logic       base_r;
    logic       base_y;
    logic       zero_r;
    logic       zero_y;
    logic       pole_p;
    logic       pole_n;
  } side_t;

  typedef struct packed {
    side_t       side;
    lane_t [2:0] lane;
  } isq_pay_t;

  function automatic logic [31:0] half_phase(input logic [15:0] a);
    logic [AMW-1:0] am;
    am = a[AMW-1:0];
    return 32'(am) << (31 - ANGLE_BITS);
  endfunction

  function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [31:0] p);
    logic [32:0] s;
    s = {1'b0, p} + (33'd1 << (31 - ANGLE_BITS));
    return ANGLE_BITS'(s >> (32 - ANGLE_BITS));
  endfunction

  function automatic logic signed [MW-1:0] mul30(input logic signed [MW-1:0] a,
                                                 input logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    p = a * b;
    p = p + ((2*MW)'(1) <<< 29);
    return MW'(p >>> 30);
  endfunction

  function automatic logic [15:0] to_q14(input logic signed [MW:0] v);
    logic signed [MW:0] r;
    r = (v + (MW+1)'(32768)) >>> 16;
    if (r > (MW+1)'(16384)) return 16'd16384;
    if (r < -(MW+1)'(16384)) return 16'hC000;
    return 16'(r);
  endfunction

endpackage

// ===== sv/quaternion_euler_converter.sv =====
// channel  | dir | tdata (low bit up)                                  | tuser
// in_      | in  | angle_roll, angle_pitch, angle_yaw, quat_w..quat_z  | opcode
// out_     | out | res_w, res_x, res_y, res_z, res_roll, res_pitch,    | -
//          |     | res_yaw                                             |
// one request per cycle while the output is not stalled; the pipe runs through the 29-cell
// square root chain and the CORDIC cell row
// reset clears only the valid bits; no clearing pass
// a stalled output freezes the whole pipe; input is taken whenever the output moves
module quaternion_euler_converter (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [qec_pkg::DW-1:0] in_tdata,  // angle_roll, angle_pitch, angle_yaw, w, x, y, z
  input  logic                   in_tuser,  // opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [qec_pkg::DW-1:0] out_tdata  // res_w, res_x, res_y, res_z, roll, pitch, yaw
);
  import qec_pkg::*;

  localparam int NV = 2 + ISQ_N + NST + 4;

  logic          adv, acc;
  logic [NV-1:0] vld_r, vld_nxt;

  logic                 p1_opc_r;
  logic [15:0]          p1_ang_r [3];
  logic signed [32:0]   p1_a_r, p1_b_r, p1_c_r, p1_d_r, p1_e_r;
  logic signed [32:0]   ew, ex, ey, ez;

  logic signed [XW-1:0] sinr, cosr, sinp, siny, cosy;
  logic signed [28:0]   sp29;
  logic signed [VW-1:0] spv, sq;
  logic [VW-1:0]        rem_nxt, rem_r;
  logic [31:0]          ph [3];
  isq_pay_t             pay_nxt;
  isq_pay_t             pay_r [ISQ_N+1];

  logic [VW-1:0] isq_v [ISQ_N];
  logic [VW-1:0] isq_q [ISQ_N];

  lane_t [2:0]   cor_in;
  lane_t [2:0]   cor_o [NST];
  side_t         sd_r [NST];
  logic [DW-1:0] post_data;
  logic [DW-1:0] out_tdata_r;

  assign adv        = !vld_r[NV-1] || out_tready;
  assign in_tready  = adv;
  assign acc        = in_tvalid && adv;
  assign out_tvalid = vld_r[NV-1];
  assign out_tdata  = out_tdata_r;
  assign vld_nxt    = {vld_r[NV-2:0], acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    ew = 33'($signed(in_tdata[63:48]));
    ex = 33'($signed(in_tdata[79:64]));
    ey = 33'($signed(in_tdata[95:80]));
    ez = 33'($signed(in_tdata[111:96]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_opc_r    <= in_tuser;
      p1_ang_r[0] <= in_tdata[15:0];
      p1_ang_r[1] <= in_tdata[31:16];
      p1_ang_r[2] <= in_tdata[47:32];
      p1_a_r      <= ew * ex + ey * ez;
      p1_b_r      <= ex * ex + ey * ey;
      p1_c_r      <= ew * ey - ez * ex;
      p1_d_r      <= ew * ez + ex * ey;
      p1_e_r      <= ey * ey + ez * ez;
    end
  end

  always_comb begin
    sinr = XW'(p1_a_r) <<< 1;
    cosr = XW'(ONE_Q28) - (XW'(p1_b_r) <<< 1);
    sinp = XW'(p1_c_r) <<< 1;
    siny = XW'(p1_d_r) <<< 1;
    cosy = XW'(ONE_Q28) - (XW'(p1_e_r) <<< 1);
    sp29 = sinp[28:0];
    spv  = VW'(sp29);
    sq   = spv * spv;
    rem_nxt = (VW'(1) << 56) - VW'(sq);
    for (int i = 0; i < 3; i++) ph[i] = half_phase(p1_ang_r[i]);

    pay_nxt.side.opc    = p1_opc_r;
    pay_nxt.side.q0     = ph[0][31:30];
    pay_nxt.side.q1     = ph[1][31:30];
    pay_nxt.side.q2     = ph[2][31:30];
    pay_nxt.side.base_r = cosr < 0;
    pay_nxt.side.base_y = cosy < 0;
    pay_nxt.side.zero_r = (sinr == 0) && (cosr == 0);
    pay_nxt.side.zero_y = (siny == 0) && (cosy == 0);
    pay_nxt.side.pole_p = sinp >= XW'(ONE_Q28);
    pay_nxt.side.pole_n = sinp <= -XW'(ONE_Q28);
    if (p1_opc_r == OPC_E2Q) begin
      for (int i = 0; i < 3; i++) begin
        pay_nxt.lane[i].rot = 1'b1;
        pay_nxt.lane[i].x   = XW'(KINV_Q30);
        pay_nxt.lane[i].y   = '0;
        pay_nxt.lane[i].z   = ZW'(ph[i][29:0]);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        pay_nxt.lane[i].rot = 1'b0;
        pay_nxt.lane[i].z   = '0;
      end
      pay_nxt.lane[0].x = (cosr < 0) ? -cosr : cosr;
      pay_nxt.lane[0].y = (cosr < 0) ? -sinr : sinr;
      pay_nxt.lane[1].x = '0;
      pay_nxt.lane[1].y = sinp;
      pay_nxt.lane[2].x = (cosy < 0) ? -cosy : cosy;
      pay_nxt.lane[2].y = (cosy < 0) ? -siny : siny;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r    <= rem_nxt;
      pay_r[0] <= pay_nxt;
      for (int j = 0; j < ISQ_N; j++) pay_r[j+1] <= pay_r[j];
    end
  end

  for (genvar j = 0; j < ISQ_N; j++) begin : g_isq
    qec_isq_cell u_cell (
      .clk (clk),
      .en  (adv),
      .k   (5'(ISQ_N - 1 - j)),
      .v_i ((j == 0) ? rem_r : isq_v[(j == 0) ? 0 : j-1]),
      .r_i ((j == 0) ? '0 : isq_q[(j == 0) ? 0 : j-1]),
      .v_o (isq_v[j]),
      .r_o (isq_q[j])
    );
  end

  always_comb begin
    cor_in = pay_r[ISQ_N].lane;
    if (pay_r[ISQ_N].side.opc == OPC_Q2E) cor_in[1].x = XW'(isq_q[ISQ_N-1][28:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= pay_r[ISQ_N].side;
      for (int j = 1; j < NST; j++) sd_r[j] <= sd_r[j-1];
    end
  end

  for (genvar j = 0; j < NST; j++) begin : g_row
    for (genvar l = 0; l < 3; l++) begin : g_lane
      qec_cordic_cell u_cell (
        .clk    (clk),
        .en     (adv),
        .sh     (5'(j)),
        .atan   (ATAN_TAB[j]),
        .lane_i ((j == 0) ? cor_in[l] : cor_o[(j == 0) ? 0 : j-1][l]),
        .lane_o (cor_o[j][l])
      );
    end
  end

  qec_post u_post (
    .clk    (clk),
    .en     (adv),
    .sd_i   (sd_r[NST-1]),
    .lane_i (cor_o[NST-1]),
    .data_o (post_data)
  );

  always_ff @(posedge clk) begin
    if (adv) out_tdata_r <= post_data;
  end
endmodule

// ===== sv/qec_isq_cell.sv =====
module qec_isq_cell (
  input  logic                    clk,
  input  logic                    en,
  input  logic [4:0]              k,
  input  logic [qec_pkg::VW-1:0]  v_i,
  input  logic [qec_pkg::VW-1:0]  r_i,
  output logic [qec_pkg::VW-1:0]  v_o,
  output logic [qec_pkg::VW-1:0]  r_o
);
  import qec_pkg::*;

  logic [VW-1:0] bit_w, t, v_nxt, r_nxt;

  always_comb begin
    bit_w = VW'(1) << {k, 1'b0};
    t     = r_i + bit_w;
    if (v_i >= t) begin
      v_nxt = v_i - t;
      r_nxt = (r_i >> 1) + bit_w;
    end else begin
      v_nxt = v_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_o <= v_nxt;
      r_o <= r_nxt;
    end
  end
endmodule

// ===== sv/qec_cordic_cell.sv =====
module qec_cordic_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     sh,
  input  logic [31:0]    atan,
  input  qec_pkg::lane_t lane_i,
  output qec_pkg::lane_t lane_o
);
  import qec_pkg::*;

  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] a;
  logic                 up;
  lane_t                lane_nxt;

  always_comb begin
    dx = lane_i.y >>> sh;
    dy = lane_i.x >>> sh;
    a  = ZW'(atan);
    up = lane_i.rot ? !lane_i.z[ZW-1] : (lane_i.y <= 0);
    lane_nxt.rot = lane_i.rot;
    if (up) begin
      lane_nxt.x = lane_i.x - dx;
      lane_nxt.y = lane_i.y + dy;
      lane_nxt.z = lane_i.z - a;
    end else begin
      lane_nxt.x = lane_i.x + dx;
      lane_nxt.y = lane_i.y - dy;
      lane_nxt.z = lane_i.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) lane_o <= lane_nxt;
  end
endmodule

// ===== sv/qec_post.sv =====
module qec_post (
  input  logic                   clk,
  input  logic                   en,
  input  qec_pkg::side_t         sd_i,
  input  qec_pkg::lane_t [2:0]   lane_i,
  output logic [qec_pkg::DW-1:0] data_o
);
  import qec_pkg::*;

  logic signed [MW-1:0] c_nxt [3];
  logic signed [MW-1:0] s_nxt [3];
  logic signed [MW-1:0] c_r [3];
  logic signed [MW-1:0] s_r [3];
  logic [1:0]           q [3];
  logic [31:0]          ph_r_nxt, ph_p_nxt, ph_y_nxt;
  logic [15:0]          ang_nxt [3];
  logic [15:0]          ang_a_r [3];
  logic [15:0]          ang_m1_r [3];
  logic [15:0]          ang_m2_r [3];
  logic                 opc_a_r, opc_m1_r, opc_m2_r;
  logic signed [MW-1:0] cr_m1_r, sr_m1_r;
  logic signed [MW-1:0] cpcy_r, spsy_r, spcy_r, cpsy_r;
  logic signed [MW-1:0] t_r [8];
  logic [15:0]          rw, rx, ry, rz;

  always_comb begin
    q[0] = sd_i.q0;
    q[1] = sd_i.q1;
    q[2] = sd_i.q2;
    for (int i = 0; i < 3; i++) begin
      case (q[i])
        2'd0: begin
          c_nxt[i] = MW'(lane_i[i].x);
          s_nxt[i] = MW'(lane_i[i].y);
        end
        2'd1: begin
          c_nxt[i] = -MW'(lane_i[i].y);
          s_nxt[i] = MW'(lane_i[i].x);
        end
        2'd2: begin
          c_nxt[i] = -MW'(lane_i[i].x);
          s_nxt[i] = -MW'(lane_i[i].y);
        end
        default: begin
          c_nxt[i] = MW'(lane_i[i].y);
          s_nxt[i] = -MW'(lane_i[i].x);
        end
      endcase
    end
    ph_r_nxt = sd_i.zero_r ? 32'd0 : ({sd_i.base_r, 31'd0} + lane_i[0].z[31:0]);
    ph_y_nxt = sd_i.zero_y ? 32'd0 : ({sd_i.base_y, 31'd0} + lane_i[2].z[31:0]);
    if (sd_i.pole_p) ph_p_nxt = QUARTER_TURN;
    else if (sd_i.pole_n) ph_p_nxt = THREE_QUART;
    else ph_p_nxt = lane_i[1].z[31:0];
    ang_nxt[0] = 16'(to_angle(ph_r_nxt));
    ang_nxt[1] = 16'(to_angle(ph_p_nxt));
    ang_nxt[2] = 16'(to_angle(ph_y_nxt));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i]      <= c_nxt[i];
        s_r[i]      <= s_nxt[i];
        ang_a_r[i]  <= ang_nxt[i];
        ang_m1_r[i] <= ang_a_r[i];
        ang_m2_r[i] <= ang_m1_r[i];
      end
      opc_a_r  <= sd_i.opc;
      opc_m1_r <= opc_a_r;
      opc_m2_r <= opc_m1_r;
      cr_m1_r  <= c_r[0];
      sr_m1_r  <= s_r[0];
      cpcy_r   <= mul30(c_r[1], c_r[2]);
      spsy_r   <= mul30(s_r[1], s_r[2]);
      spcy_r   <= mul30(s_r[1], c_r[2]);
      cpsy_r   <= mul30(c_r[1], s_r[2]);
      t_r[0]   <= mul30(cr_m1_r, cpcy_r);
      t_r[1]   <= mul30(sr_m1_r, spsy_r);
      t_r[2]   <= mul30(sr_m1_r, cpcy_r);
      t_r[3]   <= mul30(cr_m1_r, spsy_r);
      t_r[4]   <= mul30(cr_m1_r, spcy_r);
      t_r[5]   <= mul30(sr_m1_r, cpsy_r);
      t_r[6]   <= mul30(cr_m1_r, cpsy_r);
      t_r[7]   <= mul30(sr_m1_r, spcy_r);
    end
  end

  always_comb begin
    rw = to_q14((MW+1)'(t_r[0]) + (MW+1)'(t_r[1]));
    rx = to_q14((MW+1)'(t_r[2]) - (MW+1)'(t_r[3]));
    ry = to_q14((MW+1)'(t_r[4]) + (MW+1)'(t_r[5]));
    rz = to_q14((MW+1)'(t_r[6]) - (MW+1)'(t_r[7]));
    if (opc_m2_r == OPC_E2Q) begin
      data_o = {48'd0, rz, ry, rx, rw};
    end else begin
      data_o = {ang_m2_r[2], ang_m2_r[1], ang_m2_r[0], 64'd0};
    end
  end
endmodule
